[hdl/bba_pkg.sv]
package bba_pkg;

   // pool geometry default and fixed field widths
   localparam int LEVELS_DEFAULT = 10;
   localparam int UNITS_W        = 11;
   localparam int ADDR_W         = 10;
   localparam int STATUS_W       = 2;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_DONE      = 2'd0,
      RSP_NO_FIT    = 2'd1,
      RSP_NOT_FOUND = 2'd2
   } rsp_status_type;

   // datapath commands issued by the controller
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_RD_ROOT,
      CMD_TAKE_ROOT,
      CMD_MARK,
      CMD_SPLIT,
      CMD_RD_KIDS,
      CMD_SEL,
      CMD_UP_RD,
      CMD_UP_WR,
      CMD_FAIL
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    out_load;
   } ctrl_type;

   typedef struct packed {
      logic clear_last;
      logic op_free;
      logic reject;
      logic at_target;
      logic cur_split;
      logic cur_occ;
      logic align_ok;
      logic at_root;
   } dp_status_type;

endpackage

[hdl/bba_req_if.sv]
interface bba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [bba_pkg::UNITS_W-1:0]   request_units;
   logic [bba_pkg::ADDR_W-1:0]    free_address;

   modport source (output valid, req_type, request_units, free_address, input ready);
   modport sink   (input valid, req_type, request_units, free_address, output ready);
endinterface

[hdl/bba_rsp_if.sv]
interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::STATUS_W-1:0]  status;
   logic [bba_pkg::ADDR_W-1:0]    block_address;
   logic [bba_pkg::UNITS_W-1:0]   block_units;

   modport source (output valid, status, block_address, block_units, input ready);
   modport sink   (input valid, status, block_address, block_units, output ready);
endinterface

[hdl/bba_ram.sv]
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rda_addr,
   input  logic [$clog2(DEPTH)-1:0] rdb_addr,
   output logic [WIDTH-1:0]         rda_data,
   output logic [WIDTH-1:0]         rdb_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rda_data <= mem[rda_addr];
      rdb_data <= mem[rdb_addr];
   end

endmodule

[hdl/bba_ctrl.sv]
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bba_pkg::dp_status_type status,
   output bba_pkg::ctrl_type      ctrl
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CLEAR = 9'b000000010,
      S_ROOT  = 9'b000000100,
      S_RCHK  = 9'b000001000,
      S_DOWN  = 9'b000010000,
      S_SEL   = 9'b000100000,
      S_UPRD  = 9'b001000000,
      S_UPWR  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and command decode
   always_comb begin
      state_in      = state_ff;
      ctrl.cmd      = bba_pkg::CMD_NONE;
      ctrl.out_load = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ctrl.cmd = bba_pkg::CMD_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctrl.cmd = bba_pkg::CMD_LOAD;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            ctrl.cmd = bba_pkg::CMD_RD_ROOT;
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if (status.reject) begin
               ctrl.cmd = bba_pkg::CMD_FAIL;
               state_in = S_DONE;
            end else begin
               ctrl.cmd = bba_pkg::CMD_TAKE_ROOT;
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            if (!status.op_free) begin
               if (status.at_target) begin
                  ctrl.cmd = bba_pkg::CMD_MARK;
                  state_in = status.at_root ? S_DONE : S_UPRD;
               end else if (!status.cur_split) begin
                  ctrl.cmd = bba_pkg::CMD_SPLIT;
               end else begin
                  ctrl.cmd = bba_pkg::CMD_RD_KIDS;
                  state_in = S_SEL;
               end
            end else begin
               if (status.cur_occ && status.align_ok) begin
                  ctrl.cmd = bba_pkg::CMD_MARK;
                  state_in = status.at_root ? S_DONE : S_UPRD;
               end else if (status.cur_occ || !status.cur_split) begin
                  ctrl.cmd = bba_pkg::CMD_FAIL;
                  state_in = S_DONE;
               end else begin
                  ctrl.cmd = bba_pkg::CMD_RD_KIDS;
                  state_in = S_SEL;
               end
            end
         end
         S_SEL: begin
            ctrl.cmd = bba_pkg::CMD_SEL;
            state_in = S_DOWN;
         end
         S_UPRD: begin
            ctrl.cmd = bba_pkg::CMD_UP_RD;
            state_in = S_UPWR;
         end
         S_UPWR: begin
            ctrl.cmd = bba_pkg::CMD_UP_WR;
            state_in = status.at_root ? S_DONE : S_UPRD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctrl.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/bba_dpath.sv]
module bba_dpath #(
   parameter int LEVELS = bba_pkg::LEVELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bba_pkg::ctrl_type              ctrl,
   output bba_pkg::dp_status_type         status,
   input  logic                           req_type,
   input  logic [bba_pkg::UNITS_W-1:0]    request_units,
   input  logic [bba_pkg::ADDR_W-1:0]     free_address,
   output logic [bba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]     rsp_block_address,
   output logic [bba_pkg::UNITS_W-1:0]    rsp_block_units
);

   localparam int HW      = LEVELS + 1;
   localparam int DEPTH_W = $clog2(LEVELS + 1);
   localparam int DW      = $clog2(LEVELS + 2);
   localparam int WW      = DW + 1;

   // def = largest free level the node could hold minus what it holds
   typedef struct packed {
      logic          split;
      logic [DW-1:0] def;
   } node_type;

   logic [HW-1:0]                 clr_ff, clr_in;
   logic                          op_ff, op_in;
   logic                          bad_ff, bad_in;
   logic [DW-1:0]                 k_ff, k_in;
   logic [DEPTH_W-1:0]            t_ff, t_in;
   logic [LEVELS-1:0]             addr_ff, addr_in;
   logic [HW-1:0]                 h_ff, h_in;
   logic [DEPTH_W-1:0]            d_ff, d_in;
   node_type                      cur_ff, cur_in;
   logic [bba_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [bba_pkg::ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic [bba_pkg::UNITS_W-1:0]   res_units_ff, res_units_in;
   logic [bba_pkg::STATUS_W-1:0]  out_status_ff;
   logic [bba_pkg::ADDR_W-1:0]    out_addr_ff;
   logic [bba_pkg::UNITS_W-1:0]   out_units_ff;

   logic                          wr_en;
   logic [HW-1:0]                 wr_addr, rda_addr, rdb_addr;
   node_type                      wr_node;
   logic [WW-1:0]                 rda_data, rdb_data;
   node_type                      node_a, node_b;
   logic [DW-1:0]                 lf_a, lf_b, lf_max, lf_root;
   logic [DEPTH_W-1:0]            d_kid;
   logic [HW-1:0]                 node_off, align_mask;
   logic [LEVELS-1:0]             addr_shift;
   logic                          go_right;
   int                            lg_v;

   function automatic logic [DW-1:0] full_lvl(input logic [DEPTH_W-1:0] d);
      return DW'(LEVELS - int'(d) + 1);
   endfunction

   bba_ram #(
      .WIDTH (WW),
      .DEPTH (2 << LEVELS)
   ) u_tree (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_node),
      .rda_addr (rda_addr),
      .rdb_addr (rdb_addr),
      .rda_data (rda_data),
      .rdb_data (rdb_data)
   );

   assign node_a  = node_type'(rda_data);
   assign node_b  = node_type'(rdb_data);
   assign d_kid   = d_ff + DEPTH_W'(1);
   assign lf_a    = full_lvl(d_kid) - node_a.def;
   assign lf_b    = full_lvl(d_kid) - node_b.def;
   assign lf_max  = (lf_a > lf_b) ? lf_a : lf_b;
   assign lf_root = full_lvl('0) - node_a.def;

   // block start of node h at depth d, and alignment of the free address
   assign node_off   = (h_ff ^ (HW'(1) << d_ff)) << (LEVELS - int'(d_ff));
   assign align_mask = (HW'(1) << (LEVELS - int'(d_ff))) - HW'(1);
   assign addr_shift = addr_ff >> (LEVELS - 1 - int'(d_ff));
   assign go_right   = op_ff ? addr_shift[0] : (lf_a < k_ff);

   // ceiling log2 of the requested size
   always_comb begin
      lg_v = LEVELS;
      for (int i = LEVELS; i >= 0; i--) begin
         if ((32'd1 << i) >= 32'(request_units)) begin
            lg_v = i;
         end
      end
   end

   // status to the controller
   always_comb begin
      status.clear_last = &clr_ff;
      status.op_free    = op_ff;
      status.reject     = bad_ff | (~op_ff & (lf_root < k_ff));
      status.at_target  = (d_ff == t_ff);
      status.cur_split  = cur_ff.split;
      status.cur_occ    = ~cur_ff.split & (cur_ff.def != '0);
      status.align_ok   = ((HW'(addr_ff) & align_mask) == '0);
      status.at_root    = (h_ff == HW'(1));
   end

   // command execution
   always_comb begin
      clr_in        = clr_ff;
      op_in         = op_ff;
      bad_in        = bad_ff;
      k_in          = k_ff;
      t_in          = t_ff;
      addr_in       = addr_ff;
      h_in          = h_ff;
      d_in          = d_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_units_in  = res_units_ff;
      wr_en         = 1'b0;
      wr_addr       = h_ff;
      wr_node       = '0;
      rda_addr      = {h_ff[HW-2:0], 1'b0};
      rdb_addr      = {h_ff[HW-2:0], 1'b1};
      case (ctrl.cmd)
         bba_pkg::CMD_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + HW'(1);
         end
         bba_pkg::CMD_LOAD: begin
            op_in   = (req_type == bba_pkg::REQ_FREE);
            addr_in = LEVELS'(free_address);
            k_in    = DW'(lg_v + 1);
            t_in    = DEPTH_W'(LEVELS - lg_v);
            if (req_type == bba_pkg::REQ_FREE) begin
               bad_in = (32'(free_address) >= (32'd1 << LEVELS));
            end else begin
               bad_in = (request_units == '0) |
                        (32'(request_units) > (32'd1 << LEVELS));
            end
         end
         bba_pkg::CMD_RD_ROOT: begin
            rda_addr = HW'(1);
         end
         bba_pkg::CMD_TAKE_ROOT: begin
            cur_in = node_a;
            h_in   = HW'(1);
            d_in   = '0;
         end
         bba_pkg::CMD_MARK: begin
            wr_en         = 1'b1;
            wr_node.split = 1'b0;
            wr_node.def   = op_ff ? '0 : full_lvl(d_ff);
            res_status_in = bba_pkg::RSP_DONE;
            res_addr_in   = bba_pkg::ADDR_W'(node_off[LEVELS-1:0]);
            res_units_in  = bba_pkg::UNITS_W'(32'd1 << (LEVELS - int'(d_ff)));
         end
         bba_pkg::CMD_SPLIT: begin
            // right half becomes a free leaf, keep going down the left
            wr_en   = 1'b1;
            wr_addr = {h_ff[HW-2:0], 1'b1};
            h_in    = {h_ff[HW-2:0], 1'b0};
            d_in    = d_kid;
            cur_in  = '0;
         end
         bba_pkg::CMD_RD_KIDS: begin
         end
         bba_pkg::CMD_SEL: begin
            h_in   = {h_ff[HW-2:0], go_right};
            d_in   = d_kid;
            cur_in = go_right ? node_b : node_a;
         end
         bba_pkg::CMD_UP_RD: begin
            rda_addr = {h_ff[HW-1:1], 1'b0};
            rdb_addr = {h_ff[HW-1:1], 1'b1};
            h_in     = h_ff >> 1;
            d_in     = d_ff - DEPTH_W'(1);
         end
         bba_pkg::CMD_UP_WR: begin
            // two free buddy leaves merge into a free parent, else the parent is split with the larger child free level
            wr_en = 1'b1;
            if (!node_a.split && node_a.def == '0 && !node_b.split && node_b.def == '0) begin
               wr_node = '0;
            end else begin
               wr_node.split = 1'b1;
               wr_node.def   = full_lvl(d_ff) - lf_max;
            end
         end
         bba_pkg::CMD_FAIL: begin
            res_status_in = op_ff ? bba_pkg::RSP_NOT_FOUND : bba_pkg::RSP_NO_FIT;
            res_addr_in   = '0;
            res_units_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bad_ff        <= bad_in;
      k_ff          <= k_in;
      t_ff          <= t_in;
      addr_ff       <= addr_in;
      h_ff          <= h_in;
      d_ff          <= d_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_units_ff  <= res_units_in;
      if (ctrl.out_load) begin
         out_status_ff <= res_status_ff;
         out_addr_ff   <= res_addr_ff;
         out_units_ff  <= res_units_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_block_address = out_addr_ff;
   assign rsp_block_units   = out_units_ff;

   // a granted block must be a free leaf
   a_mark_free: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == bba_pkg::CMD_MARK && !op_ff) |-> (!cur_ff.split && cur_ff.def == '0))
      else $error("allocating a node that is not a free leaf");

   // an alloc descent always finds room in one child
   a_sel_room: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == bba_pkg::CMD_SEL && !op_ff) |-> (lf_a >= k_ff || lf_b >= k_ff))
      else $error("descent into a subtree with no room");

   // splitting stops above the target level
   a_split_depth: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == bba_pkg::CMD_SPLIT) |-> (d_ff < t_ff))
      else $error("split below the target level");

   // climb never goes past the root
   a_climb_root: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == bba_pkg::CMD_UP_RD) |-> (h_ff != HW'(1)))
      else $error("climb above the root");

endmodule

[hdl/buddy_block_allocator_core.sv]
// Buddy allocator core: one request in flight, one response per request.
// A rejected request goes through load, root read, root check and done. An
// allocate or free descends each tree level either by a child read and then a
// select, or by a split, and climbs back each level with a read, then a write.
// A new request waits until the last is done; a response may wait in its register.
// Reset: synchronous; afterwards a pass clears all 2^(LEVELS+1) node memory words.
module buddy_block_allocator_core #(
   parameter int LEVELS = bba_pkg::LEVELS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);

   bba_pkg::ctrl_type      ctrl;
   bba_pkg::dp_status_type status;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   bba_dpath #(
      .LEVELS (LEVELS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_type          (req_chan.req_type),
      .request_units     (req_chan.request_units),
      .free_address      (req_chan.free_address),
      .rsp_status        (rsp_chan.status),
      .rsp_block_address (rsp_chan.block_address),
      .rsp_block_units   (rsp_chan.block_units)
   );

endmodule
